@@ hw/rtl/drsp_pkg.sv @@
package drsp_pkg;

    localparam int unsigned SECTOR_SIZE = 2048;
    localparam int unsigned SECTOR_BITS = $clog2(SECTOR_SIZE);
    localparam logic [32:0] SECTOR_MASK = 33'(SECTOR_SIZE - 1);

    localparam logic [7:0] MIN_RECORD   = 8'd33;
    localparam int unsigned FLAG_DIR_BIT = 1;
    localparam logic [7:0] VERSION_MARK = 8'h3B;
    localparam logic [7:0] SELF_ID      = 8'h00;
    localparam logic [7:0] PARENT_ID    = 8'h01;

    localparam logic [7:0] POS_SECTOR_0 = 8'd2;
    localparam logic [7:0] POS_SECTOR_1 = 8'd3;
    localparam logic [7:0] POS_SECTOR_2 = 8'd4;
    localparam logic [7:0] POS_SECTOR_3 = 8'd5;
    localparam logic [7:0] POS_SIZE_0   = 8'd10;
    localparam logic [7:0] POS_SIZE_1   = 8'd11;
    localparam logic [7:0] POS_SIZE_2   = 8'd12;
    localparam logic [7:0] POS_SIZE_3   = 8'd13;
    localparam logic [7:0] POS_FLAGS    = 8'd25;
    localparam logic [7:0] POS_NAME_LEN = 8'd32;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        CFG_DIR_SIZE     = 2'd0,
        CFG_START_SECTOR = 2'd1,
        CFG_IMAGE_READY  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_CHAR  = 1'b0,
        KIND_ENTRY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [31:0] dir_size_bytes;
        logic [31:0] dir_start_sector;
        logic        image_ready;
    } cfg_t;

    typedef struct packed {
        logic [31:0] byte_offset;
        logic [7:0]  record_pos;
        logic [7:0]  record_length;
        logic [31:0] sector_word;
        logic [31:0] size_word;
        logic        dir_flag;
        logic [7:0]  name_length;
        logic [7:0]  emitted_chars;
        logic        name_stopped;
        logic        record_dropped;
        logic        skip_to_boundary;
        logic        walk_done;
    } walk_state_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        logic [31:0] entry_sector;
        logic [31:0] entry_size;
        logic        is_dir;
        logic [7:0]  name_count;
        logic        last;
    } result_t;

    localparam walk_state_t WALK_RESET = '{
        byte_offset: 32'd0, record_pos: 8'd0, record_length: 8'd0,
        sector_word: 32'd0, size_word: 32'd0, dir_flag: 1'b0,
        name_length: 8'd0, emitted_chars: 8'd0, name_stopped: 1'b0,
        record_dropped: 1'b0, skip_to_boundary: 1'b0, walk_done: 1'b1
    };

endpackage

@@ hw/rtl/drsp_step.sv @@
module drsp_step
    import drsp_pkg::*;
(
    input  cfg_t        cfg,
    input  walk_state_t state_cur,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output walk_state_t state_next,
    output result_t     res0,
    output result_t     res1,
    output logic [1:0]  res_count
);

    walk_state_t st;
    logic        at_boundary;
    logic        halt;
    logic [32:0] buf_bytes;
    logic [32:0] rec_end;
    logic [7:0]  p;
    logic [7:0]  name_idx;
    logic        char_out;
    logic [32:0] offset_inc;

    assign buf_bytes = ({1'b0, cfg.dir_size_bytes} + SECTOR_MASK) & ~SECTOR_MASK;

    always_comb begin
        st          = state_cur;
        res0        = '0;
        res1        = '0;
        res_count   = 2'd0;
        at_boundary = 1'b0;
        halt        = 1'b0;
        rec_end     = 33'd0;
        p           = 8'd0;
        name_idx    = 8'd0;
        char_out    = 1'b0;
        offset_inc  = 33'd0;

        if (first_byte) begin
            st           = WALK_RESET;
            st.walk_done = !cfg.image_ready || (cfg.dir_start_sector == 32'd0)
                           || (cfg.dir_size_bytes == 32'd0);
        end
        if (!cfg.image_ready) begin
            st.walk_done = 1'b1;
        end

        if (!st.walk_done) begin
            at_boundary = (st.byte_offset[SECTOR_BITS-1:0] == '0);
            rec_end     = {1'b0, st.byte_offset} + {25'd0, data_byte};
            if (st.skip_to_boundary && at_boundary) begin
                st.skip_to_boundary = 1'b0;
            end

            // record start
            if (!st.skip_to_boundary && st.record_length == 8'd0) begin
                if (st.byte_offset >= cfg.dir_size_bytes) begin
                    halt = 1'b1;
                end else if (data_byte == 8'd0) begin
                    if (!at_boundary) begin
                        st.skip_to_boundary = 1'b1;
                    end else begin
                        halt = 1'b1;
                    end
                end else if (rec_end > buf_bytes) begin
                    halt = 1'b1;
                end else begin
                    st.record_length  = data_byte;
                    st.record_pos     = 8'd0;
                    st.sector_word    = 32'd0;
                    st.size_word      = 32'd0;
                    st.dir_flag       = 1'b0;
                    st.name_length    = 8'd0;
                    st.emitted_chars  = 8'd0;
                    st.name_stopped   = 1'b0;
                    st.record_dropped = (data_byte < MIN_RECORD);
                end
            end

            if (halt) begin
                st.walk_done = 1'b1;
            end else begin
                if (st.record_length != 8'd0) begin
                    p = st.record_pos;
                    unique case (p)
                        POS_SECTOR_0: st.sector_word[7:0]   = data_byte;
                        POS_SECTOR_1: st.sector_word[15:8]  = data_byte;
                        POS_SECTOR_2: st.sector_word[23:16] = data_byte;
                        POS_SECTOR_3: st.sector_word[31:24] = data_byte;
                        POS_SIZE_0:   st.size_word[7:0]     = data_byte;
                        POS_SIZE_1:   st.size_word[15:8]    = data_byte;
                        POS_SIZE_2:   st.size_word[23:16]   = data_byte;
                        POS_SIZE_3:   st.size_word[31:24]   = data_byte;
                        POS_FLAGS:    st.dir_flag = data_byte[FLAG_DIR_BIT];
                        POS_NAME_LEN: begin
                            st.name_length = data_byte;
                            if (data_byte == 8'd0) begin
                                st.record_dropped = 1'b1;
                            end
                        end
                        default: ;
                    endcase

                    name_idx = p - MIN_RECORD;
                    if (p >= MIN_RECORD && name_idx < st.name_length
                        && !st.record_dropped) begin
                        if (st.name_length == 8'd1 && p == MIN_RECORD
                            && (data_byte == SELF_ID || data_byte == PARENT_ID)) begin
                            st.record_dropped = 1'b1;
                        end else if (!st.name_stopped) begin
                            if (data_byte == VERSION_MARK) begin
                                st.name_stopped = 1'b1;
                            end else begin
                                char_out         = 1'b1;
                                st.emitted_chars = st.emitted_chars + 8'd1;
                            end
                        end
                    end

                    if (char_out) begin
                        res0.kind      = KIND_CHAR;
                        res0.name_char = data_byte;
                        res0.last      = 1'b1;
                        res_count      = 2'd1;
                    end

                    // record end
                    if (({1'b0, p} + 9'd1) >= {1'b0, st.record_length}) begin
                        if (!st.record_dropped) begin
                            if (char_out) begin
                                res0.last         = 1'b0;
                                res1.kind         = KIND_ENTRY;
                                res1.entry_sector = st.sector_word;
                                res1.entry_size   = st.size_word;
                                res1.is_dir       = st.dir_flag;
                                res1.name_count   = st.emitted_chars;
                                res1.last         = 1'b1;
                                res_count         = 2'd2;
                            end else begin
                                res0.kind         = KIND_ENTRY;
                                res0.entry_sector = st.sector_word;
                                res0.entry_size   = st.size_word;
                                res0.is_dir       = st.dir_flag;
                                res0.name_count   = st.emitted_chars;
                                res0.last         = 1'b1;
                                res_count         = 2'd1;
                            end
                        end
                        st.record_length = 8'd0;
                        st.record_pos    = 8'd0;
                    end else begin
                        st.record_pos = p + 8'd1;
                    end
                end

                offset_inc     = {1'b0, st.byte_offset} + 33'd1;
                st.byte_offset = offset_inc[31:0];
                if (offset_inc[32]) begin
                    st.walk_done = 1'b1;
                end
            end
        end

        state_next = st;
    end

endmodule

@@ hw/rtl/drsp_result_fifo.sv @@
module drsp_result_fifo
    import drsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room,
    output logic       pop_valid,
    input  logic       pop_ready,
    output result_t    pop_data
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_AW:0]     count_reg;
    logic [FIFO_AW:0]     count_next;
    logic [FIFO_AW-1:0]   wr_ptr_plus1;
    logic                 pop;

    assign room         = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign pop_valid    = (count_reg != '0);
    assign pop_data     = mem[rd_ptr_reg];
    assign pop          = pop_valid && pop_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push_count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/directory_record_stream_parser.sv @@
// path: a byte taken on s_ is held in the input register, its results are
// written to the result queue, and the queue head drives the m_ ports
// throughput: one byte per cycle; a byte giving two results puts both in the
// result queue, and input stalls while three or more results wait
// reset: aresetn synchronous active low; config, walk state, input valid and
// queue pointers cleared, walk idle until a byte marked first_byte arrives
module directory_record_stream_parser
    import drsp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_first_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_name_char,
    output logic [31:0] m_entry_sector,
    output logic [31:0] m_entry_size,
    output logic        m_is_dir,
    output logic [7:0]  m_name_count,
    output logic        m_last
);

    cfg_t        cfg_reg;
    walk_state_t state_reg;
    walk_state_t state_next;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic        room;
    logic        proc_fire;
    result_t     res0;
    result_t     res1;
    logic [1:0]  res_count;
    logic [1:0]  push_count;
    result_t     head;

    assign cfg_ready  = 1'b1;
    assign proc_fire  = in_valid_reg && room;
    assign s_ready    = !in_valid_reg || proc_fire;
    assign push_count = proc_fire ? res_count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIR_SIZE:     cfg_reg.dir_size_bytes   <= cfg_data;
                CFG_START_SECTOR: cfg_reg.dir_start_sector <= cfg_data;
                CFG_IMAGE_READY:  cfg_reg.image_ready      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= WALK_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (proc_fire) begin
                state_reg <= state_next;
            end
        end
    end

    drsp_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .data_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .state_next (state_next),
        .res0       (res0),
        .res1       (res1),
        .res_count  (res_count)
    );

    drsp_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (head)
    );

    assign m_kind         = head.kind;
    assign m_name_char    = head.name_char;
    assign m_entry_sector = head.entry_sector;
    assign m_entry_size   = head.entry_size;
    assign m_is_dir       = head.is_dir;
    assign m_name_count   = head.name_count;
    assign m_last         = head.last;

endmodule

@@ sim/tb_directory_record_stream_parser.sv @@
`timescale 1ns / 1ps

import drsp_pkg::*;

typedef struct packed {
    logic       first;
    logic [7:0] data;
} dir_item_t;

typedef enum int {
    NAME_TEXT,
    NAME_RAW,
    NAME_DOTS,
    NAME_NOISE
} name_style_t;

class dir_entry_scoreboard;
    logic [31:0] extent_bytes;
    logic [31:0] start_sector;
    logic        mounted;

    logic [31:0] offset;
    logic [7:0]  rec_pos;
    logic [7:0]  rec_len;
    logic [31:0] sector_acc;
    logic [31:0] size_acc;
    logic        dir_bit;
    logic [7:0]  name_span;
    logic [7:0]  char_count;
    logic        name_ended;
    logic        rec_dropped;
    logic        skipping;
    logic        walk_idle;

    result_t pending_results[$];
    int      errors;

    function new();
        extent_bytes = '0;
        start_sector = '0;
        mounted      = 1'b0;
        clear_walk();
        walk_idle = 1'b1;
        errors    = 0;
    endfunction

    function void clear_walk();
        offset      = '0;
        rec_pos     = '0;
        rec_len     = '0;
        sector_acc  = '0;
        size_acc    = '0;
        dir_bit     = 1'b0;
        name_span   = '0;
        char_count  = '0;
        name_ended  = 1'b0;
        rec_dropped = 1'b0;
        skipping    = 1'b0;
    endfunction

    function void write_register(cfg_index_t idx, logic [31:0] value);
        case (idx)
            CFG_DIR_SIZE:     extent_bytes = value;
            CFG_START_SECTOR: start_sector = value;
            CFG_IMAGE_READY:  mounted = value[0];
            default: ;
        endcase
    endfunction

    function int outstanding();
        return pending_results.size();
    endfunction

    function void note_request(logic [7:0] b, logic first);
        result_t         fresh[$];
        result_t         r;
        longint unsigned buf_bytes;
        int unsigned     p;
        if (first) begin
            clear_walk();
            walk_idle = !mounted || start_sector == 0 || extent_bytes == 0;
        end
        if (!mounted)
            walk_idle = 1'b1;
        if (walk_idle)
            return;
        if (skipping && offset % SECTOR_SIZE == 0)
            skipping = 1'b0;
        if (!skipping && rec_len == 0) begin
            if (offset >= extent_bytes) begin
                walk_idle = 1'b1;
                return;
            end
            if (b == 8'd0) begin
                if (offset % SECTOR_SIZE == 0) begin
                    walk_idle = 1'b1;
                    return;
                end
                skipping = 1'b1;
            end else begin
                // rounded buffer end, kept in 64 bits so a full-range size cannot wrap
                buf_bytes = (64'(extent_bytes) + SECTOR_SIZE - 1) / SECTOR_SIZE * SECTOR_SIZE;
                if (64'(offset) + 64'(b) > buf_bytes) begin
                    walk_idle = 1'b1;
                    return;
                end
                rec_len     = b;
                rec_pos     = '0;
                sector_acc  = '0;
                size_acc    = '0;
                dir_bit     = 1'b0;
                name_span   = '0;
                char_count  = '0;
                name_ended  = 1'b0;
                rec_dropped = b < MIN_RECORD;
            end
        end
        if (rec_len != 0) begin
            p = rec_pos;
            if (p >= POS_SECTOR_0 && p <= POS_SECTOR_3)
                sector_acc |= 32'(b) << (8 * (p - POS_SECTOR_0));
            if (p >= POS_SIZE_0 && p <= POS_SIZE_3)
                size_acc |= 32'(b) << (8 * (p - POS_SIZE_0));
            if (p == POS_FLAGS)
                dir_bit = b[FLAG_DIR_BIT];
            if (p == POS_NAME_LEN) begin
                name_span = b;
                if (b == 8'd0)
                    rec_dropped = 1'b1;
            end
            if (p >= MIN_RECORD && p - MIN_RECORD < name_span && !rec_dropped) begin
                if (name_span == 1 && p == MIN_RECORD && (b == SELF_ID || b == PARENT_ID)) begin
                    rec_dropped = 1'b1;
                end else if (!name_ended) begin
                    if (b == VERSION_MARK) begin
                        name_ended = 1'b1;
                    end else begin
                        r           = '0;
                        r.kind      = KIND_CHAR;
                        r.name_char = b;
                        fresh.insert(fresh.size(), r);
                        char_count++;
                    end
                end
            end
            if (p + 1 >= rec_len) begin
                if (!rec_dropped) begin
                    r              = '0;
                    r.kind         = KIND_ENTRY;
                    r.entry_sector = sector_acc;
                    r.entry_size   = size_acc;
                    r.is_dir       = dir_bit;
                    r.name_count   = char_count;
                    fresh.insert(fresh.size(), r);
                end
                rec_len = '0;
                rec_pos = '0;
            end else begin
                rec_pos = 8'(p + 1);
            end
        end
        offset = offset + 32'd1;
        if (offset == 0)
            walk_idle = 1'b1;
        if (fresh.size() != 0)
            fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i])
            pending_results.insert(pending_results.size(), fresh[i]);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: result with none pending, expected nothing, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("name_char", want.name_char, got.name_char);
        compare_field("entry_sector", want.entry_sector, got.entry_sector);
        compare_field("entry_size", want.entry_size, got.entry_size);
        compare_field("is_dir", want.is_dir, got.is_dir);
        compare_field("name_count", want.name_count, got.name_count);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module tb_directory_record_stream_parser;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 450;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = '0;
    logic [31:0] cfg_data     = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte  = '0;
    logic        s_first_byte = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_kind;
    logic [7:0]  m_name_char;
    logic [31:0] m_entry_sector;
    logic [31:0] m_entry_size;
    logic        m_is_dir;
    logic [7:0]  m_name_count;
    logic        m_last;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned items_sent  = 0;
    int          quiet_cycles = 0;

    dir_entry_scoreboard sb = new();

    directory_record_stream_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_first_byte   (s_first_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_name_char    (m_name_char),
        .m_entry_sector (m_entry_sector),
        .m_entry_size   (m_entry_size),
        .m_is_dir       (m_is_dir),
        .m_name_count   (m_name_count),
        .m_last         (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_ready = (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index_t'(cfg_index), cfg_data);
            if (s_valid && s_ready)
                sb.note_request(s_data_byte, s_first_byte);
            if (m_valid && m_ready)
                sb.check_result({m_kind, m_name_char, m_entry_sector, m_entry_size,
                                 m_is_dir, m_name_count, m_last});
            quiet_cycles <= ((cfg_valid && cfg_ready) || (s_valid && s_ready) ||
                             (m_valid && m_ready)) ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (aresetn);
        while (quiet_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    task automatic write_reg(cfg_index_t idx, logic [31:0] value, bit more);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        if (!more)
            cfg_valid = 1'b0;
    endtask

    task automatic configure(logic [31:0] extent, logic [31:0] start, logic ready);
        write_reg(CFG_DIR_SIZE, extent, 1'b1);
        write_reg(CFG_START_SECTOR, start, 1'b1);
        write_reg(CFG_IMAGE_READY, {31'd0, ready}, 1'b0);
    endtask

    task automatic send_items(ref dir_item_t q[$], input int lo, input int hi);
        for (int i = lo; i < hi; i++) begin
            if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
            end
            s_valid      = 1'b1;
            s_first_byte = q[i].first;
            s_data_byte  = q[i].data;
            do @(posedge aclk); while (!s_ready);
            @(negedge aclk);
            items_sent++;
        end
        s_valid = 1'b0;
    endtask

    task automatic settle();
        while (sb.outstanding() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] name_byte(name_style_t style);
        case (style)
            NAME_TEXT: return ($urandom_range(7) == 0) ? VERSION_MARK : 8'($urandom_range(33, 126));
            NAME_DOTS: begin
                case ($urandom_range(2))
                    0: return SELF_ID;
                    1: return PARENT_ID;
                    default: return 8'h2E;
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void add_record(ref dir_item_t q[$], input int unsigned len,
                                       input int unsigned nlen, input name_style_t style);
        logic [7:0] b;
        for (int unsigned p = 0; p < len; p++) begin
            if (p == 0)
                b = 8'(len);
            else if (p == POS_NAME_LEN && style != NAME_NOISE)
                b = 8'(nlen);
            else if (p >= MIN_RECORD && p - MIN_RECORD < nlen && style != NAME_NOISE)
                b = name_byte(style);
            else
                b = 8'($urandom_range(255));
            q.insert(q.size(), {1'b0, b});
        end
    endfunction

    function automatic bit add_random_record(ref dir_item_t q[$], input int unsigned max_len,
                                             input bit allow_zero);
        int unsigned pick;
        int unsigned len;
        int unsigned nlen;
        pick = $urandom_range(99);
        if (allow_zero && pick >= 95) begin
            q.insert(q.size(), {1'b0, 8'h00});
            return 1'b1;
        end
        if (pick < 45) begin
            nlen = $urandom_range(1, 12);
            add_record(q, 33 + nlen + $urandom_range(0, 3), nlen, NAME_TEXT);
        end else if (pick < 50) begin
            nlen = $urandom_range(13, max_len - 33);
            add_record(q, 33 + nlen, nlen, NAME_TEXT);
        end else if (pick < 58) begin
            nlen = $urandom_range(1, 12);
            add_record(q, 33 + nlen + $urandom_range(0, 3), nlen, NAME_RAW);
        end else if (pick < 66) begin
            add_record(q, 34 + $urandom_range(0, 3), 1, NAME_DOTS);
        end else if (pick < 72) begin
            add_record(q, $urandom_range(33, 40), 0, NAME_TEXT);
        end else if (pick < 80) begin
            add_record(q, $urandom_range(1, 32), 0, NAME_NOISE);
        end else if (pick < 88) begin
            // name length runs past the end of the record
            len = $urandom_range(33, 45);
            add_record(q, len, $urandom_range(len - 32, 255), NAME_TEXT);
        end else begin
            add_record(q, $urandom_range(1, max_len), 0, NAME_NOISE);
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] random_sector();
        if ($urandom_range(19) == 0)
            return 32'd0;
        if ($urandom_range(9) == 0)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic run_directed();
        dir_item_t q[$];
        // nothing mounted after reset
        q = {};
        q.insert(q.size(), {1'b0, 8'hFF});
        q.insert(q.size(), {1'b1, 8'h00});
        send_items(q, 0, q.size());
        settle();
        configure(32'd0, 32'hFFFF_FFFF, 1'b1);
        q = {};
        q.insert(q.size(), {1'b1, 8'h22});
        send_items(q, 0, q.size());
        settle();
        configure(32'hFFFF_FFFF, 32'd0, 1'b1);
        send_items(q, 0, q.size());
        settle();
        write_reg(CFG_START_SECTOR, 32'd1, 1'b0);
        // zero length on a sector boundary, then a one-byte record and a skip
        q = {};
        q.insert(q.size(), {1'b1, 8'h00});
        q.insert(q.size(), {1'b0, 8'h05});
        q.insert(q.size(), {1'b1, 8'h01});
        q.insert(q.size(), {1'b0, 8'h00});
        q.insert(q.size(), {1'b0, 8'hFF});
        q.insert(q.size(), {1'b0, 8'h3B});
        q.insert(q.size(), {1'b0, 8'h80});
        send_items(q, 0, q.size());
        settle();
        write_reg(CFG_DIR_SIZE, 32'd1, 1'b0);
        q = {};
        q.insert(q.size(), {1'b1, 8'hFF});
        q.insert(q.size(), {1'b0, 8'h7F});
        send_items(q, 0, q.size());
        settle();
        // image removed inside an open record
        write_reg(CFG_IMAGE_READY, 32'd0, 1'b0);
        q = {};
        q.insert(q.size(), {1'b0, 8'h01});
        q.insert(q.size(), {1'b0, 8'hFE});
        send_items(q, 0, q.size());
        settle();
        write_reg(CFG_IMAGE_READY, 32'd1, 1'b0);
        q = {};
        q.insert(q.size(), {1'b0, 8'h40});
        send_items(q, 0, q.size());
        settle();
    endtask

    task automatic run_skip_listing();
        dir_item_t q[$];
        while (q.size() < 1800)
            void'(add_random_record(q, 60, 1'b0));
        q.insert(q.size(), {1'b0, 8'h00});
        while (q.size() < SECTOR_SIZE)
            q.insert(q.size(), {1'b0, 8'($urandom_range(255))});
        repeat (2) void'(add_random_record(q, 60, 1'b0));
        q[0].first = 1'b1;
        settle();
        configure(SECTOR_SIZE + $urandom_range(128, 1024), $urandom_range(1, 5000), 1'b1);
        send_items(q, 0, q.size());
    endtask

    task automatic run_overrun_listing();
        dir_item_t q[$];
        while (q.size() < 1800)
            void'(add_random_record(q, 60, 1'b0));
        add_record(q, 255, $urandom_range(1, 200), NAME_TEXT);
        repeat (4) q.insert(q.size(), {1'b0, 8'($urandom_range(255))});
        q[0].first = 1'b1;
        settle();
        configure(SECTOR_SIZE - $urandom_range(0, 40), $urandom_range(1, 5000), 1'b1);
        send_items(q, 0, q.size());
    endtask

    task automatic run_listing();
        dir_item_t   q[$];
        int unsigned fill;
        logic [31:0] extent;
        int          split;
        bit          ended;
        fill  = $urandom_range(40, 300);
        ended = 1'b0;
        while (!ended && q.size() < fill)
            ended = add_random_record(q, ($urandom_range(3) == 0) ? 255 : 60, 1'b1);
        if (ended)
            repeat ($urandom_range(1, 6)) q.insert(q.size(), {1'b0, 8'($urandom_range(255))});
        foreach (q[i])
            if (i != 0 && $urandom_range(99) == 0)
                q[i].first = 1'b1;
        q[0].first = 1'b1;
        case ($urandom_range(9))
            0:       extent = 32'd0;
            1:       extent = 32'hFFFF_FFFF;
            2, 3:    extent = q.size();
            4, 5:    extent = $urandom_range(1, q.size());
            6:       extent = $urandom;
            default: extent = q.size() + $urandom_range(0, 100);
        endcase
        settle();
        configure(extent, random_sector(), $urandom_range(19) != 0);
        if ($urandom_range(9) == 0) begin
            split = $urandom_range(1, q.size() - 1);
            send_items(q, 0, split);
            settle();
            if ($urandom_range(1))
                write_reg(CFG_IMAGE_READY, 32'd0, 1'b0);
            else
                write_reg(CFG_DIR_SIZE, $urandom_range(0, split + 20), 1'b0);
            send_items(q, split, q.size());
        end else begin
            send_items(q, 0, q.size());
        end
    endtask

    initial begin : stimulus
        int unsigned phase_start;
        aresetn = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        run_directed();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 23;
                    rx_idle_pct = 63;
                    run_skip_listing();
                end
                1: begin
                    tx_idle_pct = 63;
                    rx_idle_pct = 23;
                    run_overrun_listing();
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                run_listing();
        end
        settle();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
